[design/ceb_pkg.sv]
// ceb_pkg: shared types and constants of the coincidence event builder.
// No dependencies; compiled first.

package ceb_pkg;

   // Field widths
   localparam int TIME_W     = 48;
   localparam int GATE_W     = 32;
   localparam int STRIP_W    = 10;
   localparam int CNT_W      = 8;
   localparam int EVT_W      = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_GATE_NS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIP_TOL = 1'b1;

   // Register reset values
   localparam logic [GATE_W-1:0]  GATE_NS_RESET   = 32'd2000;
   localparam logic [STRIP_W-1:0] STRIP_TOL_RESET = 10'd5;

   // One input beat: a detector hit or an external trigger record
   typedef struct packed {
      logic [TIME_W-1:0] hit_time;
      logic [TIME_W-1:0] local_time;
      logic [TIME_W-1:0] trigger_time;
      logic              is_external;
      logic              detector;
      logic              side;
      logic [2:0]        asic_number;
      logic [6:0]        channel;
   } req_item_type;

   // One output beat: the summary of one detector for a closed event
   typedef struct packed {
      logic [EVT_W-1:0]  event_number;
      logic              detector_out;
      logic [CNT_W-1:0]  mult_side0;
      logic [CNT_W-1:0]  mult_side1;
      logic [CNT_W-1:0]  mult_total;
      logic [CNT_W-1:0]  true_side0;
      logic [CNT_W-1:0]  true_side1;
      logic [CNT_W-1:0]  true_total;
      logic              trig_seen;
      logic [TIME_W-1:0] ext_stamp;
      logic [CNT_W-1:0]  ext_count;
      logic              last;
   } rsp_item_type;

endpackage

[design/ceb_req_if.sv]
// ceb_req_if: valid/ready channel carrying input beats.
// Depends on ceb_pkg.

interface ceb_req_if;
   logic                    valid;
   logic                    ready;
   ceb_pkg::req_item_type   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[design/ceb_rsp_if.sv]
// ceb_rsp_if: valid/ready channel carrying event summary beats.
// Depends on ceb_pkg.

interface ceb_rsp_if;
   logic                    valid;
   logic                    ready;
   ceb_pkg::rsp_item_type   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[design/coincidence_event_builder.sv]
// Coincidence event builder. Accepts one beat per clock on req_ch, unless a staged
// closing beat is waiting, and registers it; one pass of logic (a 48-bit gate compare
// plus a few counter updates) then folds the registered beat into the open event. A
// beat whose time is farther than gate_ns from the event anchor closes the event and
// loads a summary register that sends two beats on rsp_ch (detector 0, then detector
// 1 with last set). Beats that do not close an event flow at one per cycle regardless
// of the output side; a closing beat waits only while the previous event's summary is
// still being sent, and a new event can close in the cycle in which the previous
// summary's last beat is taken.
// Depends on ceb_pkg, ceb_req_if, ceb_rsp_if.

module coincidence_event_builder #(
   parameter int MAX_HITS = 100
) (
   input  logic                               clock,
   input  logic                               reset,
   ceb_req_if.sink                            req_ch,
   ceb_rsp_if.source                          rsp_ch,
   input  logic                               csr_write,
   input  logic [ceb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ceb_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ceb_pkg::*;

   localparam logic [CNT_W-1:0] HITS_LIMIT = CNT_W'(MAX_HITS);
   localparam logic [CNT_W-1:0] CNT_MAX    = '1;

   typedef struct packed {
      logic [EVT_W-1:0]      event_number;
      logic [5:0][CNT_W-1:0] mult;
      logic [5:0][CNT_W-1:0] trues;
      logic                  trig_seen;
      logic [TIME_W-1:0]     ext_stamp;
      logic [CNT_W-1:0]      ext_count;
   } snap_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

   // configuration
   logic [GATE_W-1:0]  gate_ns_ff;
   logic [STRIP_W-1:0] strip_tol_ff;

   // input register
   logic         stage_valid_ff;
   req_item_type stage_ff;

   // event state
   logic                  open_ff, open_in;
   logic [TIME_W-1:0]     anchor_ff, anchor_in;
   logic [CNT_W-1:0]      hits_ff, hits_in;
   logic [5:0][CNT_W-1:0] mult_ff, mult_in;
   logic [5:0][CNT_W-1:0] true_ff, true_in;
   logic [3:0][STRIP_W-1:0] astrip_ff, astrip_in;
   logic [3:0]            avalid_ff, avalid_in;
   logic                  ext_seen_ff, ext_seen_in;
   logic [TIME_W-1:0]     ext_time_ff, ext_time_in;
   logic [CNT_W-1:0]      ext_rec_ff, ext_rec_in;
   logic [EVT_W-1:0]      evt_cnt_ff;

   // summary register
   logic     out_valid_ff;
   logic     out_phase_ff;
   snap_type snap_ff;

   // datapath signals
   logic [TIME_W:0]    fwd_diff, rev_diff, trg_fwd, trg_rev;
   logic [TIME_W-1:0]  anchor_gap, trig_gap;
   logic               close, opening, trig_near, advance, snap_free;
   logic [STRIP_W-1:0] strip, strip_gap;
   logic [1:0]         a_idx;
   logic [2:0]         m_idx, t_idx;
   logic               was_valid, hit_true;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ns_ff   <= GATE_NS_RESET;
         strip_tol_ff <= STRIP_TOL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GATE_NS:   gate_ns_ff   <= csr_wdata[GATE_W-1:0];
            CSR_STRIP_TOL: strip_tol_ff <= csr_wdata[STRIP_W-1:0];
            default: ;
         endcase
      end
   end

   // gate tests: anchor distance and local/trigger distance
   always_comb begin
      fwd_diff   = {1'b0, stage_ff.hit_time} - {1'b0, anchor_ff};
      rev_diff   = {1'b0, anchor_ff} - {1'b0, stage_ff.hit_time};
      anchor_gap = fwd_diff[TIME_W] ? rev_diff[TIME_W-1:0] : fwd_diff[TIME_W-1:0];
      trg_fwd    = {1'b0, stage_ff.local_time} - {1'b0, stage_ff.trigger_time};
      trg_rev    = {1'b0, stage_ff.trigger_time} - {1'b0, stage_ff.local_time};
      trig_gap   = trg_fwd[TIME_W] ? trg_rev[TIME_W-1:0] : trg_fwd[TIME_W-1:0];
      close      = open_ff && (anchor_gap > TIME_W'(gate_ns_ff));
      opening    = !open_ff || close;
      trig_near  = trig_gap < TIME_W'(gate_ns_ff);
   end

   // handshake: a closing beat needs the summary register free
   assign snap_free    = !out_valid_ff || (rsp_ch.ready && out_phase_ff);
   assign advance      = stage_valid_ff && (!close || snap_free);
   assign req_ch.ready = !stage_valid_ff || advance;

   // strip and table indexes of the hit
   always_comb begin
      strip     = {stage_ff.asic_number, stage_ff.channel};
      a_idx     = {stage_ff.detector, stage_ff.side};
      m_idx     = stage_ff.detector ? (3'd3 + {2'b0, stage_ff.side}) : {2'b0, stage_ff.side};
      t_idx     = stage_ff.detector ? 3'd5 : 3'd2;
      was_valid = opening ? 1'b0 : avalid_ff[a_idx];
      strip_gap = (astrip_ff[a_idx] >= strip) ? astrip_ff[a_idx] - strip
                                              : strip - astrip_ff[a_idx];
      hit_true  = !was_valid || (strip_gap <= strip_tol_ff);
   end

   // next event state
   always_comb begin
      open_in     = 1'b1;
      anchor_in   = opening ? stage_ff.hit_time : anchor_ff;
      hits_in     = opening ? CNT_W'(1) : sat_inc(hits_ff);
      mult_in     = opening ? '0 : mult_ff;
      true_in     = opening ? '0 : true_ff;
      astrip_in   = astrip_ff;
      avalid_in   = opening ? '0 : avalid_ff;
      ext_seen_in = opening ? 1'b0 : ext_seen_ff;
      ext_time_in = ext_time_ff;
      ext_rec_in  = opening ? '0 : ext_rec_ff;

      if (stage_ff.is_external) begin
         ext_seen_in = 1'b1;
         ext_time_in = stage_ff.hit_time;
         ext_rec_in  = opening ? CNT_W'(1) : sat_inc(ext_rec_ff);
      end else begin
         if (!opening && trig_near) begin
            ext_seen_in = 1'b1;
            ext_time_in = stage_ff.trigger_time;
         end
         for (int i = 0; i < 6; i++) begin
            if (3'(i) == m_idx || 3'(i) == t_idx) begin
               mult_in[i] = sat_inc(mult_in[i]);
               if (hit_true) begin
                  true_in[i] = sat_inc(true_in[i]);
               end
            end
         end
         if (!was_valid) begin
            avalid_in[a_idx] = 1'b1;
            astrip_in[a_idx] = strip;
         end
      end

      // overfull event is discarded
      if (hits_in >= HITS_LIMIT) begin
         open_in     = 1'b0;
         mult_in     = '0;
         true_in     = '0;
         avalid_in   = '0;
         ext_seen_in = 1'b0;
         ext_rec_in  = '0;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         stage_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         stage_ff <= req_ch.data;
      end
   end

   // event state update
   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff     <= 1'b0;
         hits_ff     <= '0;
         mult_ff     <= '0;
         true_ff     <= '0;
         avalid_ff   <= '0;
         ext_seen_ff <= 1'b0;
         ext_rec_ff  <= '0;
         evt_cnt_ff  <= '0;
      end else if (advance) begin
         open_ff     <= open_in;
         hits_ff     <= hits_in;
         mult_ff     <= mult_in;
         true_ff     <= true_in;
         avalid_ff   <= avalid_in;
         ext_seen_ff <= ext_seen_in;
         ext_rec_ff  <= ext_rec_in;
         if (close) begin
            evt_cnt_ff <= evt_cnt_ff + EVT_W'(1);
         end
      end
      if (advance) begin
         anchor_ff   <= anchor_in;
         astrip_ff   <= astrip_in;
         ext_time_ff <= ext_time_in;
      end
   end

   // summary register: two beats per closed event
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_phase_ff <= 1'b0;
      end else if (advance && close) begin
         out_valid_ff <= 1'b1;
         out_phase_ff <= 1'b0;
      end else if (out_valid_ff && rsp_ch.ready) begin
         if (out_phase_ff) begin
            out_valid_ff <= 1'b0;
         end else begin
            out_phase_ff <= 1'b1;
         end
      end
      if (advance && close) begin
         snap_ff.event_number <= evt_cnt_ff;
         snap_ff.mult         <= mult_ff;
         snap_ff.trues        <= true_ff;
         snap_ff.trig_seen    <= ext_seen_ff;
         snap_ff.ext_stamp    <= ext_seen_ff ? ext_time_ff : '0;
         snap_ff.ext_count    <= ext_rec_ff;
      end
   end

   // output beat: pick the detector half of the summary
   always_comb begin
      rsp_ch.valid             = out_valid_ff;
      rsp_ch.data.event_number = snap_ff.event_number;
      rsp_ch.data.detector_out = out_phase_ff;
      rsp_ch.data.mult_side0   = out_phase_ff ? snap_ff.mult[3]  : snap_ff.mult[0];
      rsp_ch.data.mult_side1   = out_phase_ff ? snap_ff.mult[4]  : snap_ff.mult[1];
      rsp_ch.data.mult_total   = out_phase_ff ? snap_ff.mult[5]  : snap_ff.mult[2];
      rsp_ch.data.true_side0   = out_phase_ff ? snap_ff.trues[3] : snap_ff.trues[0];
      rsp_ch.data.true_side1   = out_phase_ff ? snap_ff.trues[4] : snap_ff.trues[1];
      rsp_ch.data.true_total   = out_phase_ff ? snap_ff.trues[5] : snap_ff.trues[2];
      rsp_ch.data.trig_seen    = snap_ff.trig_seen;
      rsp_ch.data.ext_stamp    = snap_ff.ext_stamp;
      rsp_ch.data.ext_count    = snap_ff.ext_count;
      rsp_ch.data.last         = out_phase_ff;
   end

endmodule

[design/ceb_checker.sv]
// ceb_checker: port-level assertions for the coincidence event builder,
// bound to coincidence_event_builder. Depends on ceb_pkg and coincidence_event_builder.

module ceb_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input ceb_pkg::rsp_item_type rsp_data
);
   import ceb_pkg::*;

   // no summary beat right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("summary beat valid after reset");

   // stalled beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("summary beat changed while stalled");

   // detector 0 beat is followed at once by the detector 1 beat of the same event
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last |=>
         rsp_valid && rsp_data.last &&
         rsp_data.event_number == $past(rsp_data.event_number))
      else $error("second summary beat missing or from another event");

   // beat fields agree with each other
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.detector_out == rsp_data.last &&
         (rsp_data.trig_seen || rsp_data.ext_stamp == '0))
      else $error("inconsistent summary fields");

endmodule

bind coincidence_event_builder ceb_checker u_ceb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);
